>>> src/scc_pkg.sv
package scc_pkg;

  // Frame layout: bytes 0..FRAME_BYTES-2 feed the CRC, the last byte is the check byte
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned IDX_W       = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [3:0] RETRY_RESET = 4'd4;

  localparam int unsigned TEMP_W = 19;
  localparam int unsigned PROD_W = 24;
  localparam logic [TEMP_W-1:0] FAIL_TEMP = TEMP_W'(-32'sd10000);
  localparam logic [PROD_W-1:0] SCALE_MUL = PROD_W'(100);
  localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'(15);

  // Item kinds on the input tuser bit
  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  // Result status codes on the output tuser bits
  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_RETRY = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  // One registered input transaction
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // Reflected CRC-8 over one byte, LSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = din;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

>>> src/scc_in_stage.sv
module scc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [7:0]        in_tdata,
  input  logic              take,
  output scc_pkg::item_t    item
);

  logic       valid_r;
  logic       valid_nxt;
  logic       kind_r;
  logic [7:0] data_r;

  // Accept whenever the held transaction is empty or leaves this cycle
  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tvalid || (valid_r && !take);

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      data_r <= in_tdata;
    end
  end

  always_comb begin
    item.valid = valid_r;
    item.kind  = scc_pkg::kind_t'(kind_r);
    item.data  = data_r;
  end

endmodule

>>> src/scc_frame_core.sv
module scc_frame_core (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_pkg::item_t    item,
  output logic              take,
  input  logic [3:0]        retry_limit,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic [23:0]       out_tdata
);

  logic [7:0]                       crc_r, crc_nxt;
  logic [scc_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [7:0]                       low_r, low_nxt;
  logic [7:0]                       high_r, high_nxt;
  logic [3:0]                       retries_r, retries_nxt;
  logic                             out_valid_r;
  scc_pkg::status_t                 status_r, status_nxt;
  logic [scc_pkg::TEMP_W-1:0]       temp_r, temp_nxt;

  logic                             out_free;
  logic                             is_byte;
  logic                             is_last;
  logic                             emit;
  logic [15:0]                      raw;
  logic [scc_pkg::PROD_W-1:0]       prod;
  logic [scc_pkg::PROD_W-1:0]       biased;

  assign out_free = !out_valid_r || out_tready;
  assign take     = item.valid && out_free;
  assign is_byte  = (item.kind == scc_pkg::KIND_BYTE);
  assign is_last  = (idx_r >= scc_pkg::LAST_IDX);
  assign emit     = take && is_byte && is_last;

  // Scale the reading by 100/16, truncating toward zero
  always_comb begin
    raw    = {((idx_r == scc_pkg::IDX_W'(1)) ? item.data : high_r), low_r};
    prod   = {{(scc_pkg::PROD_W - 16){raw[15]}}, raw} * scc_pkg::SCALE_MUL;
    biased = prod + (prod[scc_pkg::PROD_W-1] ? scc_pkg::TRUNC_BIAS : '0);
  end

  // Next frame state and result
  always_comb begin
    crc_nxt     = crc_r;
    idx_nxt     = idx_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    retries_nxt = retries_r;
    status_nxt  = scc_pkg::ST_VALID;
    temp_nxt    = biased[scc_pkg::TEMP_W+3:4];
    if (!is_byte) begin
      crc_nxt  = '0;
      idx_nxt  = '0;
      low_nxt  = '0;
      high_nxt = '0;
    end else begin
      if (idx_r == '0) begin
        low_nxt = item.data;
      end else if (idx_r == scc_pkg::IDX_W'(1)) begin
        high_nxt = item.data;
      end
      if (!is_last) begin
        crc_nxt = scc_pkg::crc8_step(crc_r, item.data);
        idx_nxt = idx_r + scc_pkg::IDX_W'(1);
      end else begin
        crc_nxt = '0;
        idx_nxt = '0;
        if (item.data == crc_r) begin
          retries_nxt = retry_limit;
        end else if (retries_r <= 4'd1) begin
          retries_nxt = '0;
          status_nxt  = scc_pkg::ST_FAIL;
          temp_nxt    = scc_pkg::FAIL_TEMP;
        end else begin
          retries_nxt = retries_r - 4'd1;
          status_nxt  = scc_pkg::ST_RETRY;
          temp_nxt    = '0;
        end
      end
    end
  end

  // Advance frame state on each taken transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= '0;
      idx_r     <= '0;
      low_r     <= '0;
      high_r    <= '0;
      retries_r <= scc_pkg::RETRY_RESET;
    end else if (take) begin
      crc_r     <= crc_nxt;
      idx_r     <= idx_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
      retries_r <= retries_nxt;
    end
  end

  // Result register: drop when taken, load on end of frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r <= status_nxt;
      temp_r   <= temp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(24 - scc_pkg::TEMP_W){1'b0}}, temp_r};

  a_fail_clears_retries: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && status_nxt == scc_pkg::ST_FAIL) |=> (retries_r == '0))
    else $error("retry counter not held at zero after failure");

  a_good_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && status_nxt == scc_pkg::ST_VALID) |=> (retries_r == $past(retry_limit)))
    else $error("retry counter not reloaded after good frame");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (idx_r == '0 && crc_r == '0))
    else $error("frame state not cleared at end of frame");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= scc_pkg::LAST_IDX)
    else $error("byte index beyond frame");

endmodule

>>> src/scratchpad_crc_temperature_check_top.sv
// Channel | Direction | tdata                        | tuser           | Handshake
// in      | slave     | [7:0] scratch_byte           | [0] kind        | in_tvalid/in_tready
// out     | master    | [18:0] temperature_centi     | [1:0] status    | out_tvalid/out_tready
// cfg     | write     | [3:0] retry_limit            | -               | cfg_wr_en
//
// One transaction per cycle sustained while out_tready keeps the result register free; the
// check byte passes the input register, then the result register, where out_tvalid rises.
// Reset (rst_n low, synchronous) clears the frame, sets retry_limit and the retry counter to 4.
// A stalled result holds in the output register; one more transaction waits in the input
// register, then in_tready falls until out_tready rises.
module scratchpad_crc_temperature_check_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] kind
  input  logic [7:0]  in_tdata,   // [7:0] scratch_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [23:0] out_tdata,  // [18:0] temperature_centi, [23:19] zero
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  logic [3:0]     retry_limit_r;
  scc_pkg::item_t item;
  logic           take;

  // Hold the retry limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= scc_pkg::RETRY_RESET;
    end else if (cfg_wr_en) begin
      retry_limit_r <= cfg_wr_data;
    end
  end

  scc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .take      (take),
    .item      (item)
  );

  scc_frame_core u_frame_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .take        (take),
    .retry_limit (retry_limit_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule
